// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

	localparam int unsigned SIDE        = 5;
	localparam int unsigned CELLS       = SIDE * SIDE;
	localparam int unsigned FIFO_DEPTH  = 4;
	localparam int unsigned CFG_WIDTH   = 60;

	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Z = 5'd25;

	localparam logic [4:0] FINAL_CELL_RESET = LETTER_Z;

	localparam logic [1:0] REG_CIPHER_MODE       = 2'd0;
	localparam logic [1:0] REG_SQUARE_CELLS_LOW  = 2'd1;
	localparam logic [1:0] REG_SQUARE_CELLS_HIGH = 2'd2;
	localparam logic [1:0] REG_SQUARE_CELL_FINAL = 2'd3;

	typedef logic [CELLS-1:0][4:0] square_t;

	typedef struct packed {
		logic [4:0] letter_code;
		logic       final_letter;
	} in_word_t;

	typedef struct packed {
		logic [4:0] out_letter;
		logic       run_end;
	} out_word_t;

	typedef struct packed {
		logic [4:0] letter_a;
		logic [4:0] letter_b;
		logic       twice;
		logic       decrypt;
	} job_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} pos_t;

	function automatic logic [4:0] pad_for(input logic [4:0] a);
		return (a == LETTER_X) ? LETTER_Z : LETTER_X;
	endfunction

	// first cell in row-major order wins; no match -> row 0, column 0
	function automatic pos_t locate(input square_t sq, input logic [4:0] code);
		pos_t p;
		p = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[r * SIDE + c] == code) begin
					p.row = r[2:0];
					p.col = c[2:0];
				end
			end
		end
		return p;
	endfunction

	function automatic logic [2:0] step_mod5(input logic [2:0] x, input logic back);
		logic [2:0] y;
		if (back) begin
			y = (x == 3'd0) ? 3'd4 : x - 3'd1;
		end else begin
			y = (x == 3'd4) ? 3'd0 : x + 3'd1;
		end
		return y;
	endfunction

	function automatic logic [4:0] cell_at(input square_t sq, input logic [2:0] r,
	                                       input logic [2:0] c);
		logic [4:0] idx;
		idx = {r, 2'b00} + {2'b00, r} + {2'b00, c};
		return sq[idx];
	endfunction

endpackage

// ===== hw/rtl/pfc_front.sv =====
module pfc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             decrypt,
	input  logic             letter_valid,
	output logic             letter_stall,
	input  pfc_pkg::in_word_t letter,
	input  logic             job_full,
	output logic             job_push,
	output pfc_pkg::job_t    job
);

	logic       held_valid_q;
	logic [4:0] held_letter_q;
	logic       accept;
	logic [4:0] l;
	logic       held_valid_d;
	logic [4:0] held_letter_d;

	assign letter_stall = job_full;
	assign accept       = letter_valid && !job_full;
	assign l            = (letter.letter_code == pfc_pkg::LETTER_J) ?
	                      pfc_pkg::LETTER_I : letter.letter_code;

	always_comb begin
		job_push      = 1'b0;
		job.letter_a  = held_letter_q;
		job.letter_b  = l;
		job.twice     = 1'b0;
		job.decrypt   = decrypt;
		held_valid_d  = held_valid_q;
		held_letter_d = held_letter_q;
		if (accept) begin
			if (!decrypt) begin
				if (!held_valid_q) begin
					if (letter.final_letter) begin
						job_push     = 1'b1;
						job.letter_a = l;
						job.letter_b = pfc_pkg::pad_for(l);
					end else begin
						held_valid_d  = 1'b1;
						held_letter_d = l;
					end
				end else if (held_letter_q == l) begin
					// doubled letter: pad it; a final one repeats the same padded pair
					job_push     = 1'b1;
					job.letter_b = pfc_pkg::pad_for(held_letter_q);
					job.twice    = letter.final_letter;
				end else begin
					job_push     = 1'b1;
					held_valid_d = 1'b0;
				end
			end else begin
				if (held_valid_q) begin
					job_push     = 1'b1;
					held_valid_d = 1'b0;
				end else if (!letter.final_letter) begin
					held_valid_d  = 1'b1;
					held_letter_d = l;
				end
			end
			if (letter.final_letter) begin
				held_valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_letter_q <= '0;
		end else begin
			held_valid_q  <= held_valid_d;
			held_letter_q <= held_letter_d;
		end
	end

endmodule

// ===== hw/rtl/pfc_fifo.sv =====
module pfc_fifo #(
	parameter int unsigned DEPTH = pfc_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output pfc_pkg::job_t head_job
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pfc_pkg::job_t mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pfc_back.sv =====
module pfc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pfc_pkg::square_t   square,
	input  logic               job_valid,
	input  pfc_pkg::job_t      job,
	output logic               job_pop,
	output logic               cipher_valid,
	input  logic               cipher_stall,
	output pfc_pkg::out_word_t cipher
);

	pfc_pkg::pos_t p1;
	pfc_pkg::pos_t p2;
	logic [4:0]    o1;
	logic [4:0]    o2;

	logic          cur_valid_q;
	logic [4:0]    o1_q;
	logic [4:0]    o2_q;
	logic          twice_q;
	logic [1:0]    phase_q;
	logic          out_valid_q;
	pfc_pkg::out_word_t out_q;

	logic          advance;
	logic          last_phase;
	logic          load;

	always_comb begin
		p1 = pfc_pkg::locate(square, job.letter_a);
		p2 = pfc_pkg::locate(square, job.letter_b);
		if (p1.row == p2.row) begin
			o1 = pfc_pkg::cell_at(square, p1.row, pfc_pkg::step_mod5(p1.col, job.decrypt));
			o2 = pfc_pkg::cell_at(square, p2.row, pfc_pkg::step_mod5(p2.col, job.decrypt));
		end else if (p1.col == p2.col) begin
			o1 = pfc_pkg::cell_at(square, pfc_pkg::step_mod5(p1.row, job.decrypt), p1.col);
			o2 = pfc_pkg::cell_at(square, pfc_pkg::step_mod5(p2.row, job.decrypt), p2.col);
		end else begin
			o1 = pfc_pkg::cell_at(square, p1.row, p2.col);
			o2 = pfc_pkg::cell_at(square, p2.row, p1.col);
		end
	end

	assign advance    = cur_valid_q && (!out_valid_q || !cipher_stall);
	assign last_phase = twice_q ? (phase_q == 2'd3) : (phase_q == 2'd1);
	assign load       = job_valid && (!cur_valid_q || (advance && last_phase));
	assign job_pop    = load;

	assign cipher_valid = out_valid_q;
	assign cipher       = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			o1_q    <= o1;
			o2_q    <= o2;
			twice_q <= job.twice;
		end
		if (advance) begin
			out_q.out_letter <= phase_q[0] ? o2_q : o1_q;
			out_q.run_end    <= last_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= 1'b1;
				phase_q     <= '0;
			end else if (advance) begin
				cur_valid_q <= !last_phase;
				phase_q     <= phase_q + 2'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!cipher_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// channel  | valid         | stall         | word
// letters  | letter_valid  | letter_stall  | letter (letter_code, final_letter)
// cipher   | cipher_valid  | cipher_stall  | cipher (out_letter, run_end)
//
// Each digraph gives two cipher words, one per cycle while cipher_stall is low, so a letter
// stream runs at one letter per cycle, and slower while doubled or odd final letters take a pad;
// the single cipher output register sets that rate.
// A pair passes through the job queue, the o1_q/o2_q registers and out_q to the cipher port.
// Reset clears the held letter, the job queue and the output; the square resets
// to all zeros with z in the last cell. letter_stall is high only while the queue is full.
module playfair_digraph_cipher #(
	parameter int unsigned FIFO_DEPTH = pfc_pkg::FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [pfc_pkg::CFG_WIDTH-1:0]   cfg_data,
	input  logic                            letter_valid,
	output logic                            letter_stall,
	input  pfc_pkg::in_word_t               letter,
	output logic                            cipher_valid,
	input  logic                            cipher_stall,
	output pfc_pkg::out_word_t              cipher
);

	logic                          mode_q;
	logic [pfc_pkg::CFG_WIDTH-1:0] cells_low_q;
	logic [pfc_pkg::CFG_WIDTH-1:0] cells_high_q;
	logic [4:0]                    cell_final_q;
	pfc_pkg::square_t              square;

	logic          job_full;
	logic          job_push;
	pfc_pkg::job_t push_job;
	logic          job_pop;
	logic          head_valid;
	pfc_pkg::job_t head_job;

	assign square = {cell_final_q, cells_high_q, cells_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			cells_low_q  <= '0;
			cells_high_q <= '0;
			cell_final_q <= pfc_pkg::FINAL_CELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfc_pkg::REG_CIPHER_MODE:       mode_q       <= cfg_data[0];
				pfc_pkg::REG_SQUARE_CELLS_LOW:  cells_low_q  <= cfg_data;
				pfc_pkg::REG_SQUARE_CELLS_HIGH: cells_high_q <= cfg_data;
				pfc_pkg::REG_SQUARE_CELL_FINAL: cell_final_q <= cfg_data[4:0];
			endcase
		end
	end

	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.decrypt      (mode_q),
		.letter_valid (letter_valid),
		.letter_stall (letter_stall),
		.letter       (letter),
		.job_full     (job_full),
		.job_push     (job_push),
		.job          (push_job)
	);

	pfc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	pfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.square       (square),
		.job_valid    (head_valid),
		.job          (head_job),
		.job_pop      (job_pop),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher       (cipher)
	);

endmodule

// ===== hw/rtl/pfc_checker.sv =====
module pfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          letter_valid,
	input logic                          letter_stall,
	input logic                          cipher_valid,
	input logic                          cipher_stall,
	input pfc_pkg::out_word_t            cipher
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && cipher_stall |=> cipher_valid && $stable(cipher))
		else $error("stalled cipher word changed");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !cipher_valid && !letter_stall)
		else $error("activity during reset");

	a_pair_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && !cipher_stall && !cipher.run_end |=> cipher_valid)
		else $error("gap inside a digraph");

	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(letter_valid) && !$past(cipher_valid) && !cipher_valid |-> !letter_stall)
		else $error("input stalled while block idle");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

// ===== tb/sv/playfair_digraph_cipher_test.sv =====
module playfair_digraph_cipher_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 16;

	class digraph_scoreboard;
		logic       mode;
		logic [4:0] cells [CELLS];
		bit         held;
		logic [4:0] held_code;
		out_word_t  cipher_expected [$];
		int         errors;

		function new();
			mode = 1'b0;
			foreach (cells[k]) cells[k] = 5'd0;
			cells[CELLS-1] = FINAL_CELL_RESET;
			held = 1'b0;
			held_code = 5'd0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CFG_WIDTH-1:0] val);
			case (idx)
				REG_CIPHER_MODE: mode = val[0];
				REG_SQUARE_CELLS_LOW: for (int k = 0; k < 12; k++) cells[k] = val[5*k +: 5];
				REG_SQUARE_CELLS_HIGH: for (int k = 0; k < 12; k++) cells[12+k] = val[5*k +: 5];
				REG_SQUARE_CELL_FINAL: cells[CELLS-1] = val[4:0];
				default: ;
			endcase
		endfunction

		// first match in row-major order; absent letters sit at row 0, column 0
		function void find_cell(logic [4:0] code, output int r, output int c);
			bit found;
			found = 1'b0;
			r = 0;
			c = 0;
			for (int k = 0; k < CELLS; k++) begin
				if (!found && cells[k] == code) begin
					found = 1'b1;
					r = k / SIDE;
					c = k % SIDE;
				end
			end
		endfunction

		function logic [4:0] pad_letter(logic [4:0] a);
			return (a == LETTER_X) ? LETTER_Z : LETTER_X;
		endfunction

		function void encode_pair(logic [4:0] a, logic [4:0] b, bit closing);
			int r1, c1, r2, c2, sh;
			out_word_t w;
			logic [4:0] o1, o2;
			sh = mode ? SIDE - 1 : 1;
			find_cell(a, r1, c1);
			find_cell(b, r2, c2);
			if (r1 == r2) begin
				o1 = cells[r1*SIDE + (c1+sh)%SIDE];
				o2 = cells[r2*SIDE + (c2+sh)%SIDE];
			end else if (c1 == c2) begin
				o1 = cells[((r1+sh)%SIDE)*SIDE + c1];
				o2 = cells[((r2+sh)%SIDE)*SIDE + c2];
			end else begin
				o1 = cells[r1*SIDE + c2];
				o2 = cells[r2*SIDE + c1];
			end
			w.out_letter = o1;
			w.run_end = 1'b0;
			cipher_expected.push_back(w);
			w.out_letter = o2;
			w.run_end = closing;
			cipher_expected.push_back(w);
		endfunction

		function void note_letter(in_word_t w);
			logic [4:0] code;
			code = w.letter_code;
			if (code == LETTER_J) code = LETTER_I;
			if (!mode) begin
				if (!held) begin
					if (w.final_letter) begin
						encode_pair(code, pad_letter(code), 1'b1);
					end else begin
						held = 1'b1;
						held_code = code;
					end
				end else if (held_code == code) begin
					encode_pair(code, pad_letter(code), !w.final_letter);
					if (w.final_letter) encode_pair(code, pad_letter(code), 1'b1);
				end else begin
					encode_pair(held_code, code, 1'b1);
					held = 1'b0;
				end
			end else begin
				if (held) begin
					encode_pair(held_code, code, 1'b1);
					held = 1'b0;
				end else if (!w.final_letter) begin
					held = 1'b1;
					held_code = code;
				end
			end
			if (w.final_letter) held = 1'b0;
		endfunction

		function void check_cipher(out_word_t got);
			out_word_t want;
			if (cipher_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected word letter=%0d end=%0b", $realtime,
					         got.out_letter, got.run_end);
				return;
			end
			want = cipher_expected.pop_front();
			if (got.out_letter !== want.out_letter || got.run_end !== want.run_end) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch letter exp=%0d got=%0d end exp=%0b got=%0b",
					         $realtime, want.out_letter, got.out_letter, want.run_end,
					         got.run_end);
			end
		endfunction

		function int pending();
			return cipher_expected.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [1:0]           cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;
	logic                 letter_valid;
	logic                 letter_stall;
	in_word_t             letter;
	logic                 cipher_valid;
	logic                 cipher_stall;
	out_word_t            cipher;

	digraph_scoreboard sb = new();
	int                cycles = 0;
	int                send_style;
	int                recv_style;
	logic [4:0]        sq_now [CELLS];

	playfair_digraph_cipher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.letter_valid (letter_valid),
		.letter_stall (letter_stall),
		.letter       (letter),
		.cipher_valid (cipher_valid),
		.cipher_stall (cipher_stall),
		.cipher       (cipher)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("playfair_digraph_cipher_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && letter_valid && !letter_stall) sb.note_letter(letter);
		if (arst_n && cipher_valid && !cipher_stall) sb.check_cipher(cipher);
	end

	// style 0: never waits, 1: always random, 2: mostly back to back
	function int draw_wait(int style);
		case (style)
			0: return 0;
			1: return int'($urandom_range(0, 18));
			default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
		endcase
	endfunction

	initial begin
		int n;
		cipher_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			n = draw_wait(recv_style);
			if (n > 0) begin
				cipher_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			cipher_stall <= 1'b0;
			@(posedge clk);
			while (!cipher_valid) @(posedge clk);
		end
	end

	task automatic send(input logic [4:0] code, input logic fin);
		in_word_t w;
		int gap;
		w.letter_code = code;
		w.final_letter = fin;
		gap = draw_wait(send_style);
		if (gap > 0) begin
			letter_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		letter_valid <= 1'b1;
		letter <= w;
		@(posedge clk);
		while (letter_stall) @(posedge clk);
	endtask

	task automatic drain();
		letter_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_square(input logic [CFG_WIDTH-1:0] lo, input logic [CFG_WIDTH-1:0] hi,
	                           input logic [CFG_WIDTH-1:0] fin);
		write_reg(REG_SQUARE_CELLS_LOW, lo);
		write_reg(REG_SQUARE_CELLS_HIGH, hi);
		write_reg(REG_SQUARE_CELL_FINAL, fin);
		for (int k = 0; k < 12; k++) begin
			sq_now[k] = lo[5*k +: 5];
			sq_now[12+k] = hi[5*k +: 5];
		end
		sq_now[CELLS-1] = fin[4:0];
	endtask

	// shuffle = 0 gives the plain alphabet square without j
	task automatic load_permutation(input bit shuffle);
		logic [4:0] perm [CELLS];
		logic [4:0] t;
		logic [CFG_WIDTH-1:0] lo, hi, fin;
		int j;
		for (int k = 0; k < CELLS; k++) perm[k] = (k < LETTER_J) ? 5'(k) : 5'(k + 1);
		if (shuffle) begin
			for (int k = CELLS - 1; k > 0; k--) begin
				j = int'($urandom_range(0, k));
				t = perm[k];
				perm[k] = perm[j];
				perm[j] = t;
			end
		end
		lo = '0;
		hi = '0;
		fin = '0;
		for (int k = 0; k < 12; k++) begin
			lo[5*k +: 5] = perm[k];
			hi[5*k +: 5] = perm[12+k];
		end
		fin[4:0] = perm[CELLS-1];
		load_square(lo, hi, fin);
	endtask

	function logic [CFG_WIDTH-1:0] rand_word();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[CFG_WIDTH-1:0];
	endfunction

	task automatic random_phase(input int count);
		logic [4:0] code, prev;
		logic fin;
		int pick, msg_left;
		prev = sq_now[0];
		msg_left = int'($urandom_range(1, 9));
		for (int i = 0; i < count; i++) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 15) code = prev;
			else if (pick < 30) code = 5'($urandom_range(0, 31));
			else code = sq_now[$urandom_range(0, CELLS - 1)];
			msg_left--;
			fin = (msg_left == 0) && ($urandom_range(0, 7) != 0);
			if (msg_left == 0) msg_left = int'($urandom_range(1, 9));
			send(code, fin);
			prev = code;
		end
	endtask

	initial begin
		send_style = 1;
		recv_style = 1;
		for (int k = 0; k < CELLS; k++) sq_now[k] = 5'd0;
		sq_now[CELLS-1] = FINAL_CELL_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CIPHER_MODE;
		cfg_data <= '0;
		letter_valid <= 1'b0;
		letter <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// squares straight out of reset
		send(5'd0, 1'b0);
		send(LETTER_Z, 1'b1);
		send(5'd31, 1'b1);
		drain();

		load_permutation(1'b0);
		write_reg(REG_CIPHER_MODE, '0);
		send(5'd1, 1'b0);
		send(5'd3, 1'b0);
		send(5'd0, 1'b0);
		send(5'd21, 1'b0);
		send(5'd7, 1'b0);
		send(5'd18, 1'b0);
		send(5'd11, 1'b0);
		send(5'd11, 1'b0);
		send(5'd14, 1'b0);
		send(LETTER_J, 1'b0);
		send(5'd10, 1'b0);
		send(LETTER_X, 1'b0);
		send(LETTER_X, 1'b1);
		send(5'd6, 1'b1);
		send(5'd4, 1'b0);
		send(5'd12, 1'b1);
		send(5'd26, 1'b0);
		send(5'd30, 1'b0);
		send(5'd19, 1'b0);
		drain();

		// t is still held across the mode switch
		write_reg(REG_CIPHER_MODE, {{(CFG_WIDTH-1){1'b0}}, 1'b1});
		send(5'd2, 1'b0);
		send(5'd3, 1'b0);
		send(5'd3, 1'b0);
		send(5'd13, 1'b1);
		send(5'd20, 1'b0);
		send(5'd24, 1'b1);
		drain();

		for (int p = 0; p < 10; p++) begin
			send_style = int'($urandom_range(0, 2));
			recv_style = int'($urandom_range(0, 2));
			case (p % 4)
				0, 1: load_permutation(1'b1);
				2: load_square(rand_word(), rand_word(), rand_word());
				default: begin
					if (p == 3) load_square('0, '0, '0);
					else load_square('1, '1, '1);
				end
			endcase
			if (p < 2) write_reg(REG_CIPHER_MODE, CFG_WIDTH'(p));
			else write_reg(REG_CIPHER_MODE, rand_word());
			random_phase(23);
			drain();
		end

		if (sb.errors == 0) begin
			$display("playfair_digraph_cipher_test: done, clean");
		end else begin
			$display("playfair_digraph_cipher_test: done, errors");
		end
		$finish;
	end

endmodule
